/* sv/lpic_pkg.sv */
package lpic_pkg;

  // field widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEVEL_W    = 3;
  localparam int unsigned INDEX_W    = 5;
  localparam int unsigned FUNC_W     = 2;

  // control register layout
  localparam int unsigned REQ_BIT    = 3;
  localparam logic [BYTE_W-1:0] REQ_MASK   = 8'h08;

  // sources reduced together in the first search step
  localparam int unsigned GROUP_SIZE = 8;

  // item function codes
  localparam logic [FUNC_W-1:0] FN_READ  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_WRITE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_LINE  = 2'd2;
  localparam logic [FUNC_W-1:0] FN_ACK   = 2'd3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic exec;   // apply the item and reduce each group
    logic merge;  // combine group results into the result registers
  } lpic_cmd_t;

endpackage

/* sv/lpic_ctrl.sv */
module lpic_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lpic_pkg::lpic_cmd_t cmd_o
);
  import lpic_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MERGE = 2'd1;
  localparam logic [1:0] ST_OUT   = 2'd2;

  logic [1:0] state_q, state_d;
  logic       in_accept;

  // take a new item when idle or when the waiting result leaves this cycle
  assign in_stall_o  = !((state_q == ST_IDLE) || ((state_q == ST_OUT) && !out_stall_i));
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == ST_OUT);

  // commands to the datapath
  always_comb begin
    cmd_o.exec  = in_accept;
    cmd_o.merge = (state_q == ST_MERGE);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) state_d = ST_MERGE;
      end
      ST_MERGE: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall_i) state_d = in_accept ? ST_MERGE : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/lpic_datapath.sv */
module lpic_datapath #(
  parameter int unsigned NUM_SOURCES = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  lpic_pkg::lpic_cmd_t                   cmd_i,
  input  logic [lpic_pkg::FUNC_W-1:0]           func_i,
  input  logic [lpic_pkg::INDEX_W-1:0]          source_index_i,
  input  logic [lpic_pkg::BYTE_W-1:0]           write_byte_i,
  input  logic                                  line_is_low_i,
  output logic [lpic_pkg::BYTE_W-1:0]           read_byte_o,
  output logic [lpic_pkg::LEVEL_W-1:0]          top_level_o,
  output logic                                  winner_valid_o,
  output logic [lpic_pkg::INDEX_W-1:0]          winner_index_o
);
  import lpic_pkg::*;

  localparam int unsigned IdxW      = $clog2(NUM_SOURCES);
  localparam int unsigned ExtW      = (IdxW > INDEX_W) ? IdxW : INDEX_W;
  localparam int unsigned NumGroups = (NUM_SOURCES + GROUP_SIZE - 1) / GROUP_SIZE;

  logic [BYTE_W-1:0]  ctrl_q [NUM_SOURCES];
  logic [BYTE_W-1:0]  view   [NUM_SOURCES];

  logic [ExtW-1:0]    addr_ext;
  logic [IdxW-1:0]    addr;
  logic               hit;
  logic [BYTE_W-1:0]  cur_byte;
  logic [BYTE_W-1:0]  new_byte;

  logic [LEVEL_W-1:0] grp_lvl_d [NumGroups];
  logic [IdxW-1:0]    grp_idx_d [NumGroups];
  logic [LEVEL_W-1:0] grp_lvl_q [NumGroups];
  logic [IdxW-1:0]    grp_idx_q [NumGroups];

  logic [LEVEL_W-1:0] best_lvl;
  logic [IdxW-1:0]    best_idx;
  logic [ExtW-1:0]    best_ext;

  logic [BYTE_W-1:0]  rd_q;
  logic [LEVEL_W-1:0] top_q;
  logic               wv_q;
  logic [INDEX_W-1:0] widx_q;

  // address decode, sources beyond the count are ignored
  assign addr_ext = ExtW'(source_index_i);
  assign addr     = addr_ext[IdxW-1:0];
  assign hit      = (32'(source_index_i) < NUM_SOURCES);
  assign cur_byte = hit ? ctrl_q[addr] : '0;

  // register update for the current item
  always_comb begin
    case (func_i)
      FN_READ:  new_byte = cur_byte;
      FN_WRITE: new_byte = write_byte_i | (cur_byte & REQ_MASK);
      FN_LINE:  new_byte = line_is_low_i ? (cur_byte | REQ_MASK) : cur_byte;
      FN_ACK:   new_byte = cur_byte & ~REQ_MASK;
      default:  new_byte = cur_byte;
    endcase
  end

  // register file as seen after this item
  always_comb begin
    for (int unsigned k = 0; k < NUM_SOURCES; k++) begin
      view[k] = (hit && (addr == IdxW'(k))) ? new_byte : ctrl_q[k];
    end
  end

  // first search step: best level and lowest index inside each group
  always_comb begin
    int unsigned k;
    for (int unsigned g = 0; g < NumGroups; g++) begin
      grp_lvl_d[g] = '0;
      grp_idx_d[g] = '0;
      for (int unsigned j = 0; j < GROUP_SIZE; j++) begin
        k = g * GROUP_SIZE + j;
        if (k < NUM_SOURCES) begin
          if (view[k][REQ_BIT] && (view[k][LEVEL_W-1:0] > grp_lvl_d[g])) begin
            grp_lvl_d[g] = view[k][LEVEL_W-1:0];
            grp_idx_d[g] = IdxW'(k);
          end
        end
      end
    end
  end

  // second search step: groups in ascending order, strict compare keeps lowest index
  always_comb begin
    best_lvl = '0;
    best_idx = '0;
    for (int unsigned g = 0; g < NumGroups; g++) begin
      if (grp_lvl_q[g] > best_lvl) begin
        best_lvl = grp_lvl_q[g];
        best_idx = grp_idx_q[g];
      end
    end
  end

  assign best_ext = ExtW'(best_idx);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned k = 0; k < NUM_SOURCES; k++) begin
        ctrl_q[k] <= '0;
      end
    end else if (cmd_i.exec && hit) begin
      ctrl_q[addr] <= new_byte;
    end
  end

  // read data and group results
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rd_q <= (hit && (func_i == FN_READ)) ? cur_byte : '0;
      for (int unsigned g = 0; g < NumGroups; g++) begin
        grp_lvl_q[g] <= grp_lvl_d[g];
        grp_idx_q[g] <= grp_idx_d[g];
      end
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.merge) begin
      top_q  <= best_lvl;
      wv_q   <= (best_lvl != '0);
      widx_q <= best_ext[INDEX_W-1:0];
    end
  end

  assign read_byte_o    = rd_q;
  assign top_level_o    = top_q;
  assign winner_valid_o = wv_q;
  assign winner_index_o = widx_q;

endmodule

/* sv/level_priority_interrupt_controller_top.sv */
// Level-priority interrupt controller: one 8-bit control register per source
// (level in bits 2..0, request flag in bit 3). Each item reads, writes, raises
// or acknowledges one source, and yields one result with the read byte and the
// current winner: the highest pending level above zero and the lowest source at
// that level. The accept cycle of an item updates the register and reduces the
// sources in groups of eight, the next cycle merges the group results into the
// output registers. The result then waits until taken; the next item is
// accepted in the cycle the result leaves. The control registers read zero
// after reset; the result registers are not reset.
module level_priority_interrupt_controller_top #(
  parameter int unsigned NUM_SOURCES = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [lpic_pkg::FUNC_W-1:0]  func_i,
  input  logic [lpic_pkg::INDEX_W-1:0] source_index_i,
  input  logic [lpic_pkg::BYTE_W-1:0]  write_byte_i,
  input  logic                         line_is_low_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [lpic_pkg::BYTE_W-1:0]  read_byte_o,
  output logic [lpic_pkg::LEVEL_W-1:0] top_level_o,
  output logic                         winner_valid_o,
  output logic [lpic_pkg::INDEX_W-1:0] winner_index_o
);
  import lpic_pkg::*;

  lpic_cmd_t cmd;

  // handshake and sequencing
  lpic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // register file and priority search
  lpic_datapath #(
    .NUM_SOURCES (NUM_SOURCES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .func_i         (func_i),
    .source_index_i (source_index_i),
    .write_byte_i   (write_byte_i),
    .line_is_low_i  (line_is_low_i),
    .read_byte_o    (read_byte_o),
    .top_level_o    (top_level_o),
    .winner_valid_o (winner_valid_o),
    .winner_index_o (winner_index_o)
  );

`ifndef NO_ASSERTIONS
  // an accepted item passes through the merge state to a valid result
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> ##2 out_valid_o)
    else $error("result not ready two cycles after accept");

  // no new item while a result is held back
  a_hold_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("item accepted while result stalled");

  // winner flag agrees with the reported level
  a_winner_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (winner_valid_o == (top_level_o != '0)))
    else $error("winner flag and level disagree");

  // no winner means index zero
  a_no_winner_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !winner_valid_o) |-> (winner_index_o == '0))
    else $error("index set without a winner");
`endif

endmodule
